// ----- rtl/lsr_pkg.sv -----
// shared types and codes for the lifo stack with remove-by-value
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

    // field widths
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 7;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // what one cell holds and hands to its neighbors
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic              mark;
    } t_slot;

    // operation applied to every cell in a cycle
    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_PUSH  = 3'd1,
        OP_POP   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_MARK  = 3'd4,
        OP_SWEEP = 3'd5
    } t_cell_op;

    // broadcast control to the row of cells
    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] key;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/lsr_cell.sv -----
// one stack cell: holds an entry and trades it with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module lsr_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsr_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_pair_up,
    input  wire logic              i_pair_dn,
    input  wire lsr_pkg::t_slot    i_up,
    input  wire lsr_pkg::t_slot    i_dn,
    output lsr_pkg::t_slot         o_slot
);
    import lsr_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic              r_valid;
    logic              r_mark;
    logic [DATA_W-1:0] n_data;
    logic              n_valid;
    logic              n_mark;
    logic              w_match;

    assign w_match = r_valid && (r_data == i_ctl.key);

    // next slot contents per broadcast operation
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        n_mark  = r_mark;
        case (i_ctl.op)
            OP_PUSH: begin
                n_data  = i_up.data;
                n_valid = i_up.valid;
            end
            OP_POP: begin
                n_data  = i_dn.data;
                n_valid = i_dn.valid;
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            OP_MARK: begin
                n_mark  = w_match;
                n_valid = r_valid && !w_match;
            end
            OP_SWEEP: begin
                // marks drain toward the top, holes sink past live entries
                n_mark = i_dn.mark;
                if (i_pair_dn && !r_valid && i_dn.valid) begin
                    n_data  = i_dn.data;
                    n_valid = 1'b1;
                end else if (i_pair_up && !i_up.valid && r_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_data  = r_data;
            end
        endcase
    end

    // control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_mark  <= n_mark;
        end
    end

    // entry data
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_slot = '{data: r_data, valid: r_valid, mark: r_mark};

endmodule

`default_nettype wire

// ----- rtl/lifo_stack_remove_by_value.sv -----
// top level: lifo stack of signed 32-bit values with remove-by-value
//
// Input channel i_in_valid / o_in_ready carries one command item (i_cmd, i_value):
// push, pop, remove all entries equal to i_value, or clear. Output channel
// o_out_valid / i_out_ready returns exactly one result item per command with
// popped value, removed count, occupancy after the command, and status.
// The store is a row of DEPTH cells with the top entry in cell 0; push and
// pop shift the whole row by one cell.
// Push, pop and clear finish in the accept cycle: the result is valid on the
// next cycle. Remove first marks the matches, then runs odd-even rounds in
// which holes sink past live entries while the match marks drain through
// cell 0 into a counter, and then posts the result once the output is free.
// One command is in work at a time; a new one is accepted while idle as soon
// as the output register is empty or being taken in that cycle.
// If the receiver stalls, the result holds in the output register and a
// finished remove waits; no result is lost.
// Reset empties the store at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lifo_stack_remove_by_value #(
    parameter int DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [lsr_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic signed [lsr_pkg::DATA_W-1:0] i_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [lsr_pkg::DATA_W-1:0] o_popped_value,
    output logic [lsr_pkg::CNT_W-1:0]        o_removed_count,
    output logic [lsr_pkg::CNT_W-1:0]        o_occupancy,
    output logic [lsr_pkg::STAT_W-1:0]       o_status
);
    import lsr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_WAIT  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_rm, n_rm;
    logic [CW-1:0]     r_step, n_step;
    logic              r_phase, n_phase;
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_pop, n_pop;
    logic [CW-1:0]     r_orm, n_orm;
    logic [CW-1:0]     r_occ, n_occ;
    logic [STAT_W-1:0] r_stat, n_stat;

    t_cell_ctl         w_ctl;
    t_slot             w_slot [DEPTH];
    t_slot             w_top_in;
    t_slot             w_bot_in;
    logic [DEPTH-1:0]  w_pair_up;
    logic [DEPTH-1:0]  w_pair_dn;
    logic              w_in_fire;
    logic              w_out_free;
    logic              w_full;
    logic              w_empty;
    logic [CW+CNT_W-1:0] w_rm_wide;
    logic [CW+CNT_W-1:0] w_occ_wide;

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // edge feeds of the row: push value enters at the top, holes at the bottom
    assign w_top_in = '{data: i_value, valid: 1'b1, mark: 1'b0};
    assign w_bot_in = '{data: '0, valid: 1'b0, mark: 1'b0};

    // row of cells with odd-even pairing for the compaction rounds
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_slot w_up;
        t_slot w_dn;

        assign w_pair_dn[gi] = (gi < DEPTH - 1) && (r_phase == 1'(gi % 2));
        assign w_pair_up[gi] = (gi > 0) && (r_phase == 1'((gi + 1) % 2));

        if (gi == 0) begin : g_top
            assign w_up = w_top_in;
        end else begin : g_mid_up
            assign w_up = w_slot[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_bot
            assign w_dn = w_bot_in;
        end else begin : g_mid_dn
            assign w_dn = w_slot[gi+1];
        end

        lsr_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_pair_up (w_pair_up[gi]),
            .i_pair_dn (w_pair_dn[gi]),
            .i_up      (w_up),
            .i_dn      (w_dn),
            .o_slot    (w_slot[gi])
        );
    end

    // sequencer, count and result register
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rm     = r_rm;
        n_step   = r_step;
        n_phase  = r_phase;
        n_ovalid = r_ovalid;
        n_pop    = r_pop;
        n_orm    = r_orm;
        n_occ    = r_occ;
        n_stat   = r_stat;
        w_ctl.op  = OP_HOLD;
        w_ctl.key = i_value;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_pop  = '0;
                    n_orm  = '0;
                    n_stat = ST_OK;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (w_full) begin
                                n_stat = ST_FULL;
                            end else begin
                                w_ctl.op = OP_PUSH;
                                n_count  = r_count + CW'(1);
                            end
                            n_ovalid = 1'b1;
                        end
                        CMD_POP: begin
                            if (w_empty) begin
                                n_stat = ST_EMPTY;
                            end else begin
                                w_ctl.op = OP_POP;
                                n_count  = r_count - CW'(1);
                                n_pop    = w_slot[0].data;
                            end
                            n_ovalid = 1'b1;
                        end
                        CMD_REMOVE: begin
                            w_ctl.op = OP_MARK;
                            n_rm     = '0;
                            n_step   = '0;
                            n_phase  = 1'b0;
                            n_state  = S_SWEEP;
                        end
                        default: begin
                            w_ctl.op = OP_CLEAR;
                            n_count  = '0;
                            n_ovalid = 1'b1;
                        end
                    endcase
                    n_occ = n_count;
                end
            end
            S_SWEEP: begin
                w_ctl.op = OP_SWEEP;
                n_rm     = r_rm + CW'(w_slot[0].mark);
                n_phase  = !r_phase;
                n_step   = r_step + CW'(1);
                if (r_step == CW'(DEPTH - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_out_free) begin
                    n_count  = r_count - r_rm;
                    n_pop    = '0;
                    n_orm    = r_rm;
                    n_occ    = r_count - r_rm;
                    n_stat   = ST_OK;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rm     <= '0;
            r_step   <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rm     <= n_rm;
            r_step   <= n_step;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_pop  <= n_pop;
        r_orm  <= n_orm;
        r_occ  <= n_occ;
        r_stat <= n_stat;
    end

    // counts leave as their low bits
    assign w_rm_wide  = {{CNT_W{1'b0}}, r_orm};
    assign w_occ_wide = {{CNT_W{1'b0}}, r_occ};

    assign o_out_valid     = r_ovalid;
    assign o_popped_value  = r_pop;
    assign o_removed_count = w_rm_wide[CNT_W-1:0];
    assign o_occupancy     = w_occ_wide[CNT_W-1:0];
    assign o_status        = r_stat;

endmodule

`default_nettype wire

// ----- sim/tb_lifo_stack_remove_by_value.sv -----
// testbench for the lifo stack with remove-by-value: directed table, then random traffic
`timescale 1ns / 1ps

module tb_lifo_stack_remove_by_value;
    import lsr_pkg::*;

    localparam int DEPTH           = 64;
    localparam int RAND_ITEMS      = 1750;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = DEPTH + 4;

    // one result item as the block reports it
    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic [CNT_W-1:0]         removed;
        logic [CNT_W-1:0]         occ;
        logic [STAT_W-1:0]        status;
    } stack_result_t;

    // one row of the directed table
    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
        int                       reps;
        bit                       typed;
        stack_result_t            want;
    } stim_row_t;

    // command mix of a stretch of random traffic
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_mix_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [CMD_W-1:0]           i_cmd;
    logic signed [DATA_W-1:0]   i_value;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [DATA_W-1:0]   o_popped_value;
    logic [CNT_W-1:0]           o_removed_count;
    logic [CNT_W-1:0]           o_occupancy;
    logic [STAT_W-1:0]          o_status;

    // shadow copy of the stack, slot 0 at the bottom
    logic signed [DATA_W-1:0]   shadow_mem [DEPTH];
    int                         shadow_cnt;

    stack_result_t              replies_due [$];
    stim_row_t                  stim_tab [$];
    logic signed [DATA_W-1:0]   key_pool [8] = '{32'sd0, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
                                                 32'sd1, 32'sd7, 32'sd42, -32'sd100};
    int                         mismatches;
    int                         stall_cycles;
    bit                         no_gaps;
    bit                         hold_off_req;

    lifo_stack_remove_by_value #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_value (o_popped_value),
        .o_removed_count(o_removed_count),
        .o_occupancy    (o_occupancy),
        .o_status       (o_status)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one command to the shadow stack and return what the block should report
    function automatic stack_result_t stack_apply(logic [CMD_W-1:0] cmd,
                                                  logic signed [DATA_W-1:0] value);
        stack_result_t r;
        int kept;
        r = '0;
        kept = 0;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_cnt < DEPTH) begin
                    shadow_mem[shadow_cnt] = value;
                    shadow_cnt++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_POP: begin
                if (shadow_cnt > 0) begin
                    shadow_cnt--;
                    r.popped = shadow_mem[shadow_cnt];
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            CMD_REMOVE: begin
                // compact survivors toward the bottom, order kept
                for (int i = 0; i < shadow_cnt; i++) begin
                    if (shadow_mem[i] !== value) begin
                        shadow_mem[kept] = shadow_mem[i];
                        kept++;
                    end
                end
                r.removed = CNT_W'(shadow_cnt - kept);
                shadow_cnt = kept;
            end
            default: begin
                shadow_cnt = 0;
            end
        endcase
        r.occ = CNT_W'(shadow_cnt);
        return r;
    endfunction

    function automatic void add_row(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value,
                                    int reps, bit typed, logic signed [DATA_W-1:0] popped,
                                    int removed, int occ, logic [STAT_W-1:0] status);
        stim_row_t row;
        row.cmd          = cmd;
        row.value        = value;
        row.reps         = reps;
        row.typed        = typed;
        row.want.popped  = popped;
        row.want.removed = CNT_W'(removed);
        row.want.occ     = CNT_W'(occ);
        row.want.status  = status;
        stim_tab.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // offer one command item, hold it until taken, then record its expected result
    task automatic offer_cmd(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] value,
                             input bit typed, input stack_result_t typed_want);
        stack_result_t r;
        while (!no_gaps && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        r = stack_apply(cmd, value);
        replies_due.push_back(typed ? typed_want : r);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int held;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                held = 0;
                i_out_ready <= 1'b0;
                while (held < HOLD_OFF_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end
            i_out_ready <= no_gaps || ($urandom_range(99) >= 8);
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        stack_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result with none expected, popped %0h occupancy %0d",
                         $time, o_popped_value, o_occupancy);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                check_field("popped_value", want.popped, o_popped_value);
                check_field("removed_count", DATA_W'(want.removed), DATA_W'(o_removed_count));
                check_field("occupancy", DATA_W'(want.occ), DATA_W'(o_occupancy));
                check_field("status", DATA_W'(want.status), DATA_W'(o_status));
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus
    initial begin
        stack_result_t            no_want;
        traffic_mix_t             mix;
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
        int                       pick;
        int                       push_top;
        int                       pop_top;

        no_want      = '0;
        mix          = MIX_EVEN;
        mismatches   = 0;
        stall_cycles = 0;
        shadow_cnt   = 0;
        no_gaps      = 1'b0;
        hold_off_req = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd      <= CMD_PUSH;
        i_value    <= '0;

        // empty store: pop, remove and clear
        add_row(CMD_POP,    0, 1, 1, 0, 0, 0, ST_EMPTY);
        add_row(CMD_REMOVE, 0, 1, 1, 0, 0, 0, ST_OK);
        add_row(CMD_CLEAR,  0, 1, 1, 0, 0, 0, ST_OK);
        // extremes of the value field
        add_row(CMD_PUSH, 32'h7FFF_FFFF, 1, 1, 0, 0, 1, ST_OK);
        add_row(CMD_PUSH, 32'h8000_0000, 1, 1, 0, 0, 2, ST_OK);
        add_row(CMD_PUSH, -32'sd1,       1, 1, 0, 0, 3, ST_OK);
        add_row(CMD_PUSH, 32'sd0,        1, 1, 0, 0, 4, ST_OK);
        add_row(CMD_PUSH, -32'sd1,       1, 1, 0, 0, 5, ST_OK);
        add_row(CMD_REMOVE, -32'sd1,     1, 1, 0, 2, 3, ST_OK);
        // remove with no match
        add_row(CMD_REMOVE, 32'sd12345,  1, 1, 0, 0, 3, ST_OK);
        add_row(CMD_POP, 0, 1, 1, 32'sd0,        0, 2, ST_OK);
        add_row(CMD_POP, 0, 1, 1, 32'h8000_0000, 0, 1, ST_OK);
        add_row(CMD_POP, 0, 1, 1, 32'h7FFF_FFFF, 0, 0, ST_OK);
        add_row(CMD_POP, 0, 1, 1, 0, 0, 0, ST_EMPTY);
        // remove keeps the order of the survivors
        add_row(CMD_PUSH, 32'sd10, 1, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH, 32'sd20, 1, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH, 32'sd10, 1, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH, 32'sd30, 1, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH, 32'sd10, 1, 0, 0, 0, 0, ST_OK);
        add_row(CMD_REMOVE, 32'sd10, 1, 1, 0, 3, 2, ST_OK);
        add_row(CMD_POP, 0, 1, 1, 32'sd30, 0, 1, ST_OK);
        add_row(CMD_POP, 0, 1, 1, 32'sd20, 0, 0, ST_OK);
        // fill to the top, push on full, then remove every entry at once
        add_row(CMD_PUSH, 32'sd5, DEPTH, 0, 0, 0, 0, ST_OK);
        add_row(CMD_PUSH, 32'sd6, 1, 1, 0, 0, DEPTH, ST_FULL);
        add_row(CMD_REMOVE, 32'sd5, 1, 1, 0, DEPTH, 0, ST_OK);
        // clear a partly filled store
        add_row(CMD_PUSH, 32'sd3, 3, 0, 0, 0, 0, ST_OK);
        add_row(CMD_CLEAR, -32'sd1, 1, 1, 0, 0, 0, ST_OK);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (stim_tab[k]) begin
            repeat (stim_tab[k].reps) begin
                offer_cmd(stim_tab[k].cmd, stim_tab[k].value, stim_tab[k].typed,
                          stim_tab[k].want);
            end
        end

        // random traffic in stretches that fill, drain or churn the stack
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 120 == 0) begin
                mix = traffic_mix_t'($urandom_range(2));
            end
            if (n == 300) begin
                hold_off_req = 1'b1;
            end
            no_gaps = (n >= 700 && n < 1000);
            case (mix)
                MIX_FILL: begin
                    push_top = 75;
                    pop_top  = 85;
                end
                MIX_DRAIN: begin
                    push_top = 25;
                    pop_top  = 85;
                end
                default: begin
                    push_top = 45;
                    pop_top  = 80;
                end
            endcase
            pick = $urandom_range(99);
            if (pick < push_top) begin
                cmd = CMD_PUSH;
            end else if (pick < pop_top) begin
                cmd = CMD_POP;
            end else if (pick < 97) begin
                cmd = CMD_REMOVE;
            end else begin
                cmd = CMD_CLEAR;
            end
            // removes mostly aim at a value that is held
            if (cmd == CMD_REMOVE && shadow_cnt > 0 && $urandom_range(9) < 7) begin
                value = shadow_mem[$urandom_range(shadow_cnt - 1)];
            end else if ($urandom_range(9) < 4) begin
                value = key_pool[$urandom_range(7)];
            end else begin
                value = $urandom;
            end
            offer_cmd(cmd, value, 1'b0, no_want);
        end
        no_gaps = 1'b0;
        i_in_valid <= 1'b0;

        // let every result come back, then allow for stragglers
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lsr_pkg.sv
rtl/lsr_cell.sv
rtl/lifo_stack_remove_by_value.sv
sim/tb_lifo_stack_remove_by_value.sv
